// ----- rtl/plsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_pkg
// Shared constants, codes and control types of the pinned LRU cache table.
// ----------------------------------------------------------------------------
package plsc_pkg;

    localparam int CAP_BITS     = 40;
    localparam int REF_BITS     = 16;
    localparam int OUT_KEY_BITS = 32;
    localparam int OP_BITS      = 4;
    localparam int ST_BITS      = 3;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64'd1073741824);

    localparam logic [OP_BITS-1:0] OP_INSERT  = 4'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE  = 4'd1;
    localparam logic [OP_BITS-1:0] OP_LOOKUP  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIRTY   = 4'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAN   = 4'd4;
    localparam logic [OP_BITS-1:0] OP_ACQUIRE = 4'd5;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 4'd6;
    localparam logic [OP_BITS-1:0] OP_PIN     = 4'd7;
    localparam logic [OP_BITS-1:0] OP_UNPIN   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_CLEAR   = 4'd9;

    localparam logic [ST_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [ST_BITS-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_BITS-1:0] ST_REFUSED   = 3'd2;
    localparam logic [ST_BITS-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [ST_BITS-1:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        SA_NONE,
        SA_NEWEST,
        SA_DROP_EV,
        SA_DROP_MATCH,
        SA_ADMIT,
        SA_DIRTY,
        SA_CLEAN,
        SA_ACQ,
        SA_REL,
        SA_PIN,
        SA_UNPIN
    } slot_act_t;

    typedef enum logic [1:0] {
        RS_NONE,
        RS_MATCH,
        RS_FREE
    } rep_sel_t;

    typedef struct packed {
        logic               load;
        logic               scan_init;
        logic               scan_step;
        slot_act_t          act;
        logic               emit_report;
        logic               set_reply;
        rep_sel_t           rep_sel;
        logic [ST_BITS-1:0] rep_status;
        logic               emit_reply;
    } dp_cmd_t;

    typedef struct packed {
        logic               scan_last;
        logic [OP_BITS-1:0] op;
        logic               match_found;
        logic               match_busy;
        logic               free_found;
        logic               ev_found;
        logic               fits;
        logic               freed_ge;
        logic               out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/plsc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_if
// Channel interfaces: operation requests, results and capacity writes.
// ----------------------------------------------------------------------------
interface plsc_req_if #(
    parameter int KEY_BITS  = 32,
    parameter int SIZE_BITS = 40
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           op;
    logic [KEY_BITS-1:0]  object_key;
    logic [SIZE_BITS-1:0] object_size;

    modport source (output valid, output op, output object_key, output object_size,
                    input ready);
    modport sink   (input valid, input op, input object_key, input object_size,
                    output ready);
endinterface

interface plsc_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [2:0]  status;
    logic [31:0] reported_key;
    logic        is_cached;
    logic        is_dirty;
    logic        is_pinned;
    logic [15:0] reference_count;
    logic [39:0] used_bytes;
    logic        last;

    modport source (output valid, output result_kind, output status, output reported_key,
                    output is_cached, output is_dirty, output is_pinned,
                    output reference_count, output used_bytes, output last, input ready);
    modport sink   (input valid, input result_kind, input status, input reported_key,
                    input is_cached, input is_dirty, input is_pinned,
                    input reference_count, input used_bytes, input last, output ready);
endinterface

interface plsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [39:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/plsc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_datapath
// Slot table, scan unit, byte accounting and the result register.
// ----------------------------------------------------------------------------
module plsc_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32,
    parameter int SIZE_BITS     = 40
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire plsc_pkg::dp_cmd_t                 cmd,
    output      plsc_pkg::dp_stat_t                stat,
    input  wire logic [plsc_pkg::OP_BITS-1:0]      op_in,
    input  wire logic [KEY_BITS-1:0]               key_in,
    input  wire logic [SIZE_BITS-1:0]              size_in,
    input  wire logic                              cfg_we,
    input  wire logic [plsc_pkg::CAP_BITS-1:0]     cfg_data,
    input  wire logic                              out_ready,
    output      logic                              out_valid,
    output      logic                              out_kind,
    output      logic [plsc_pkg::ST_BITS-1:0]      out_status,
    output      logic [plsc_pkg::OUT_KEY_BITS-1:0] out_key,
    output      logic                              out_cached,
    output      logic                              out_dirty,
    output      logic                              out_pinned,
    output      logic [plsc_pkg::REF_BITS-1:0]     out_refs,
    output      logic [plsc_pkg::CAP_BITS-1:0]     out_used,
    output      logic                              out_last
);
    import plsc_pkg::*;

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int FW  = ((CAP_BITS > SIZE_BITS) ? CAP_BITS : SIZE_BITS) + 1;
    localparam int FRW = SIZE_BITS + IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // slot table
    logic                 slot_valid_reg [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]  slot_key_reg   [TABLE_ENTRIES];
    logic [SIZE_BITS-1:0] slot_size_reg  [TABLE_ENTRIES];
    logic [IW-1:0]        slot_rank_reg  [TABLE_ENTRIES];
    logic [REF_BITS-1:0]  slot_refs_reg  [TABLE_ENTRIES];
    logic                 slot_pin_reg   [TABLE_ENTRIES];
    logic                 slot_dirty_reg [TABLE_ENTRIES];

    logic [CAP_BITS-1:0]  total_reg, total_next;
    logic [CAP_BITS-1:0]  cap_reg;

    // latched item
    logic [OP_BITS-1:0]   op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [FRW-1:0]       freed_reg;

    // scan results
    logic [IW-1:0] idx_reg;
    logic          match_found_reg, free_found_reg, ev_found_reg;
    logic [IW-1:0] match_idx_reg, free_idx_reg, ev_idx_reg, ev_rank_reg;

    // reply selection
    logic          rep_have_reg;
    logic [IW-1:0] rep_idx_reg;
    logic [ST_BITS-1:0] rep_status_reg;

    logic          out_valid_reg;
    logic          out_free;
    logic [IW-1:0] tgt;
    logic [IW-1:0] tgt_rank;
    logic [FW-1:0] need;
    logic [KEY_BITS+OUT_KEY_BITS-1:0] rep_key_ext, ev_key_ext;

    assign out_free = !out_valid_reg || out_ready;
    assign need     = FW'(total_reg) + FW'(size_reg);

    always_comb
    begin
        unique case (cmd.act)
            SA_DROP_EV: tgt = ev_idx_reg;
            SA_ADMIT:   tgt = free_idx_reg;
            default:    tgt = match_idx_reg;
        endcase
    end

    assign tgt_rank = slot_rank_reg[tgt];

    always_comb
    begin
        total_next = total_reg;
        if (cmd.act == SA_DROP_EV || cmd.act == SA_DROP_MATCH)
            total_next = total_reg - CAP_BITS'(slot_size_reg[tgt]);
        else if (cmd.act == SA_ADMIT)
            total_next = total_reg + CAP_BITS'(size_reg);
    end

    assign stat.scan_last   = (idx_reg == LAST_IDX);
    assign stat.op          = op_reg;
    assign stat.match_found = match_found_reg;
    assign stat.match_busy  = (slot_refs_reg[match_idx_reg] != '0) || slot_pin_reg[match_idx_reg];
    assign stat.free_found  = free_found_reg;
    assign stat.ev_found    = ev_found_reg;
    assign stat.fits        = (need <= FW'(cap_reg));
    assign stat.freed_ge    = (freed_reg >= FRW'(size_reg));
    assign stat.out_free    = out_free;

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            total_reg <= total_next;
            if (cmd.emit_report || cmd.emit_reply)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.act == SA_DROP_EV || cmd.act == SA_DROP_MATCH)
                slot_valid_reg[tgt] <= 1'b0;
            else if (cmd.act == SA_ADMIT)
                slot_valid_reg[tgt] <= 1'b1;
        end
    end

    // slot payload, scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_in;
            key_reg   <= key_in;
            size_reg  <= size_in;
            freed_reg <= '0;
        end
        else if (cmd.act == SA_DROP_EV)
            freed_reg <= freed_reg + FRW'(slot_size_reg[tgt]);

        if (cmd.scan_init)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            ev_found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (slot_valid_reg[idx_reg] && slot_key_reg[idx_reg] == key_reg
                && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
            if (!slot_valid_reg[idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (slot_valid_reg[idx_reg] && slot_refs_reg[idx_reg] == '0
                && !slot_pin_reg[idx_reg]
                && (!ev_found_reg || slot_rank_reg[idx_reg] > ev_rank_reg))
            begin
                ev_found_reg <= 1'b1;
                ev_idx_reg   <= idx_reg;
                ev_rank_reg  <= slot_rank_reg[idx_reg];
            end
        end

        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            unique case (cmd.act)
                SA_NEWEST, SA_ACQ:
                begin
                    if (IW'(i) == tgt)
                        slot_rank_reg[i] <= '0;
                    else if (slot_valid_reg[i] && slot_rank_reg[i] < tgt_rank)
                        slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
                end
                SA_DROP_EV, SA_DROP_MATCH:
                begin
                    if (IW'(i) != tgt && slot_valid_reg[i] && slot_rank_reg[i] > tgt_rank)
                        slot_rank_reg[i] <= slot_rank_reg[i] - 1'b1;
                end
                SA_ADMIT:
                begin
                    if (IW'(i) == tgt)
                        slot_rank_reg[i] <= '0;
                    else if (slot_valid_reg[i])
                        slot_rank_reg[i] <= slot_rank_reg[i] + 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        unique case (cmd.act)
            SA_ADMIT:
            begin
                slot_key_reg[tgt]   <= key_reg;
                slot_size_reg[tgt]  <= size_reg;
                slot_refs_reg[tgt]  <= '0;
                slot_pin_reg[tgt]   <= 1'b0;
                slot_dirty_reg[tgt] <= 1'b0;
            end
            SA_DIRTY: slot_dirty_reg[tgt] <= 1'b1;
            SA_CLEAN: slot_dirty_reg[tgt] <= 1'b0;
            SA_ACQ:
            begin
                if (slot_refs_reg[tgt] != REF_MAX)
                    slot_refs_reg[tgt] <= slot_refs_reg[tgt] + 1'b1;
            end
            SA_REL:
            begin
                if (slot_refs_reg[tgt] != '0)
                    slot_refs_reg[tgt] <= slot_refs_reg[tgt] - 1'b1;
            end
            SA_PIN:   slot_pin_reg[tgt] <= 1'b1;
            SA_UNPIN: slot_pin_reg[tgt] <= 1'b0;
            default:
            begin
            end
        endcase

        if (cmd.set_reply)
        begin
            rep_status_reg <= cmd.rep_status;
            unique case (cmd.rep_sel)
                RS_MATCH:
                begin
                    rep_have_reg <= match_found_reg;
                    rep_idx_reg  <= match_idx_reg;
                end
                RS_FREE:
                begin
                    rep_have_reg <= 1'b1;
                    rep_idx_reg  <= free_idx_reg;
                end
                default:
                begin
                    rep_have_reg <= 1'b0;
                    rep_idx_reg  <= match_idx_reg;
                end
            endcase
        end

        if (cmd.emit_report)
        begin
            out_kind   <= 1'b1;
            out_status <= ST_OK;
            out_key    <= ev_key_ext[OUT_KEY_BITS-1:0];
            out_cached <= 1'b0;
            out_dirty  <= slot_dirty_reg[ev_idx_reg];
            out_pinned <= 1'b0;
            out_refs   <= '0;
            out_used   <= total_next;
            out_last   <= 1'b0;
        end
        else if (cmd.emit_reply)
        begin
            out_kind   <= 1'b0;
            out_status <= rep_status_reg;
            out_key    <= rep_key_ext[OUT_KEY_BITS-1:0];
            out_cached <= rep_have_reg;
            out_dirty  <= rep_have_reg && slot_dirty_reg[rep_idx_reg];
            out_pinned <= rep_have_reg && slot_pin_reg[rep_idx_reg];
            out_refs   <= rep_have_reg ? slot_refs_reg[rep_idx_reg] : '0;
            out_used   <= total_reg;
            out_last   <= 1'b1;
        end
    end

    assign rep_key_ext = {{OUT_KEY_BITS{1'b0}}, key_reg};
    assign ev_key_ext  = {{OUT_KEY_BITS{1'b0}}, slot_key_reg[ev_idx_reg]};
    assign out_valid   = out_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/plsc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_ctrl
// Sequencer: scan, decide, evict loop and reply.
// ----------------------------------------------------------------------------
module plsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output      logic               req_ready,
    input  wire plsc_pkg::dp_stat_t stat,
    output      plsc_pkg::dp_cmd_t  cmd
);
    import plsc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT, S_REPLY} state_t;

    state_t state_reg, state_next;
    logic   evict_reg, evict_next;

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            evict_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            evict_reg <= evict_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.act    = SA_NONE;
        cmd.rep_sel = RS_NONE;
        state_next = state_reg;
        evict_next = evict_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.scan_init = 1'b1;
                    evict_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_ACT;
            end
            S_ACT:
            begin
                // default outcome: reply about the requested key
                cmd.set_reply  = 1'b1;
                cmd.rep_sel    = RS_MATCH;
                cmd.rep_status = ST_OK;
                state_next     = S_REPLY;
                priority if (stat.op == OP_INSERT)
                begin
                    if (stat.match_found)
                        cmd.act = SA_NEWEST;
                    else if ((!evict_reg && stat.fits)
                             || (evict_reg && (stat.freed_ge || !stat.ev_found)))
                    begin
                        if (stat.fits && stat.free_found)
                        begin
                            cmd.act     = SA_ADMIT;
                            cmd.rep_sel = RS_FREE;
                        end
                        else
                        begin
                            cmd.rep_sel    = RS_NONE;
                            cmd.rep_status = stat.fits ? ST_FULL : ST_NO_SPACE;
                        end
                    end
                    else if (!evict_reg && !stat.ev_found)
                    begin
                        cmd.rep_sel    = RS_NONE;
                        cmd.rep_status = ST_NO_SPACE;
                    end
                    else
                    begin
                        cmd.set_reply = 1'b0;
                        state_next    = S_ACT;
                        if (stat.out_free)
                        begin
                            cmd.act         = SA_DROP_EV;
                            cmd.emit_report = 1'b1;
                            cmd.scan_init   = 1'b1;
                            evict_next      = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                end
                else if (stat.op == OP_CLEAR)
                begin
                    if (stat.ev_found)
                    begin
                        cmd.set_reply = 1'b0;
                        state_next    = S_ACT;
                        if (stat.out_free)
                        begin
                            cmd.act         = SA_DROP_EV;
                            cmd.emit_report = 1'b1;
                            cmd.scan_init   = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                end
                else if (stat.op > OP_CLEAR)
                begin
                    cmd.rep_sel = RS_MATCH;
                end
                else if (!stat.match_found)
                begin
                    cmd.rep_sel    = RS_NONE;
                    cmd.rep_status = ST_NOT_FOUND;
                end
                else
                begin
                    unique case (stat.op)
                        OP_REMOVE:
                        begin
                            if (stat.match_busy)
                                cmd.rep_status = ST_REFUSED;
                            else
                            begin
                                cmd.act     = SA_DROP_MATCH;
                                cmd.rep_sel = RS_NONE;
                            end
                        end
                        OP_DIRTY:   cmd.act = SA_DIRTY;
                        OP_CLEAN:   cmd.act = SA_CLEAN;
                        OP_ACQUIRE: cmd.act = SA_ACQ;
                        OP_RELEASE: cmd.act = SA_REL;
                        OP_PIN:     cmd.act = SA_PIN;
                        OP_UNPIN:   cmd.act = SA_UNPIN;
                        default:    cmd.act = SA_NONE;
                    endcase
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_reply = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/pinned_lru_size_cache_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_lru_size_cache_table
// Keyed object table with size accounting, LRU eviction, pinning and refs.
// ----------------------------------------------------------------------------
// One operation at a time. Each pass over the table is a scan, one slot
// per cycle, that finds the key, the first free slot and the oldest
// evictable entry. A plain operation goes from transfer through the scan
// and a decide step to the reply. Each eviction or clear report is
// followed by a rescan of the table. Results leave through a registered
// output stage; a stalled result holds the sequencer. Capacity writes are
// taken at any time (ready is tied high) and should only come while the
// block is idle.
// ----------------------------------------------------------------------------
module pinned_lru_size_cache_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32,
    parameter int SIZE_BITS     = 40
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    plsc_req_if.sink   req,
    plsc_rsp_if.source rsp,
    plsc_cfg_if.sink   cfg
);
    import plsc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_fire_ok;

    // capacity register always takes the transfer
    assign cfg.ready = 1'b1;

    plsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_fire_ok),
        .stat      (stat),
        .cmd       (cmd)
    );

    assign req.ready = req_fire_ok;

    plsc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .SIZE_BITS     (SIZE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op_in      (req.op),
        .key_in     (req.object_key),
        .size_in    (req.object_size),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_kind   (rsp.result_kind),
        .out_status (rsp.status),
        .out_key    (rsp.reported_key),
        .out_cached (rsp.is_cached),
        .out_dirty  (rsp.is_dirty),
        .out_pinned (rsp.is_pinned),
        .out_refs   (rsp.reference_count),
        .out_used   (rsp.used_bytes),
        .out_last   (rsp.last)
    );

endmodule
`default_nettype wire

// ----- tb/cache_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_table_checker
// Watches the request, result and capacity channels of the cache table,
// predicts the result stream of every accepted operation and compares it.
// ----------------------------------------------------------------------------
module cache_table_checker
    import plsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    plsc_req_if   req,
    plsc_rsp_if   rsp,
    plsc_cfg_if   cfg,
    output int    fail_count,
    output int    pending,
    output int    op_count,
    output int    result_count,
    output int    evict_count
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic                kind;
        logic [ST_BITS-1:0]  status;
        logic [31:0]         key;
        logic                cached;
        logic                dirty;
        logic                pinned;
        logic [15:0]         refs;
        logic [CAP_BITS-1:0] used;
        logic                last;
    } cache_result_t;

    cache_result_t result_q[$];

    logic [CAP_BITS-1:0] capacity;
    logic [CAP_BITS-1:0] used_total;
    bit                  live[SLOTS];
    logic [31:0]         slot_key[SLOTS];
    logic [CAP_BITS-1:0] slot_size[SLOTS];
    int                  rank[SLOTS];
    int                  refs[SLOTS];
    bit                  pinned[SLOTS];
    bit                  dirty[SLOTS];

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    // oldest entry that nobody holds and that is not pinned
    function automatic int oldest_victim();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && refs[i] == 0 && !pinned[i])
                if (best < 0 || rank[i] > rank[best])
                    best = i;
        return best;
    endfunction

    function automatic void make_newest(int s);
        for (int i = 0; i < SLOTS; i++)
            if (i != s && live[i] && rank[i] < rank[s])
                rank[i]++;
        rank[s] = 0;
    endfunction

    function automatic void drop_slot(int s);
        live[s]    = 0;
        used_total = used_total - slot_size[s];
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && rank[i] > rank[s])
                rank[i]--;
    endfunction

    function automatic void evict_and_report(int s);
        cache_result_t r;
        r        = '0;
        r.kind   = 1'b1;
        r.status = ST_OK;
        r.key    = slot_key[s];
        r.dirty  = dirty[s];
        drop_slot(s);
        r.used   = used_total;
        result_q = {result_q, r};
        evict_count++;
    endfunction

    function automatic void predict_operation(logic [3:0] op, logic [31:0] k,
                                              logic [CAP_BITS-1:0] size);
        cache_result_t r;
        logic [ST_BITS-1:0] st;
        logic [63:0] freed;
        int s, c;
        bit refused;
        st = ST_OK;
        s  = find_slot(k);
        if (op == OP_INSERT) begin
            refused = 0;
            if (s >= 0)
                make_newest(s);
            else begin
                if (64'(used_total) + 64'(size) > 64'(capacity)) begin
                    c = oldest_victim();
                    if (c < 0)
                        refused = 1;
                    else begin
                        freed = 0;
                        while (c >= 0) begin
                            freed += 64'(slot_size[c]);
                            evict_and_report(c);
                            if (freed >= 64'(size))
                                break;
                            c = oldest_victim();
                        end
                        refused = 64'(used_total) + 64'(size) > 64'(capacity);
                    end
                end
                if (refused)
                    st = ST_NO_SPACE;
                else begin
                    for (int i = 0; i < SLOTS && s < 0; i++)
                        if (!live[i])
                            s = i;
                    if (s < 0)
                        st = ST_FULL;
                    else begin
                        for (int i = 0; i < SLOTS; i++)
                            if (live[i])
                                rank[i]++;
                        live[s]      = 1;
                        slot_key[s]  = k;
                        slot_size[s] = size;
                        rank[s]      = 0;
                        refs[s]      = 0;
                        pinned[s]    = 0;
                        dirty[s]     = 0;
                        used_total   = used_total + size;
                    end
                end
            end
        end else if (op == OP_CLEAR) begin
            for (c = oldest_victim(); c >= 0; c = oldest_victim())
                evict_and_report(c);
            s = find_slot(k);
        end else if (op <= OP_CLEAR) begin
            if (s < 0)
                st = ST_NOT_FOUND;
            else
                case (op)
                    OP_REMOVE:
                        if (refs[s] != 0 || pinned[s])
                            st = ST_REFUSED;
                        else begin
                            drop_slot(s);
                            s = -1;
                        end
                    OP_DIRTY:   dirty[s] = 1;
                    OP_CLEAN:   dirty[s] = 0;
                    OP_ACQUIRE:
                    begin
                        if (refs[s] < int'(REF_MAX))
                            refs[s]++;
                        make_newest(s);
                    end
                    OP_RELEASE: if (refs[s] > 0) refs[s]--;
                    OP_PIN:     pinned[s] = 1;
                    OP_UNPIN:   pinned[s] = 0;
                    default:    ;
                endcase
        end
        // unused op codes fall through with status ok
        r        = '0;
        r.status = st;
        r.key    = k;
        r.used   = used_total;
        r.last   = 1'b1;
        if (s >= 0) begin
            r.cached = 1'b1;
            r.dirty  = dirty[s];
            r.pinned = pinned[s];
            r.refs   = 16'(refs[s]);
        end
        result_q = {result_q, r};
    endfunction

    function automatic string show(cache_result_t r);
        return $sformatf({"kind=%0d st=%0d key=%h cached=%0d dirty=%0d pin=%0d",
                          " refs=%0d used=%0d last=%0d"},
                         r.kind, r.status, r.key, r.cached, r.dirty, r.pinned, r.refs,
                         r.used, r.last);
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t got;
        cache_result_t want;
        if (!rst_n) begin
            result_q.delete();
            capacity     = CAP_RESET;
            used_total   = '0;
            for (int i = 0; i < SLOTS; i++)
                live[i] = 0;
            fail_count   = 0;
            op_count     = 0;
            result_count = 0;
            evict_count  = 0;
        end else begin
            if (cfg.valid && cfg.ready)
                capacity = cfg.data;
            if (rsp.valid && rsp.ready) begin
                got = {rsp.result_kind, rsp.status, rsp.reported_key, rsp.is_cached,
                       rsp.is_dirty, rsp.is_pinned, rsp.reference_count, rsp.used_bytes,
                       rsp.last};
                result_count++;
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transfer\n  expected none\n  actual   %s",
                             $time, show(got));
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                 $time, show(want), show(got));
                    end
                end
            end
            if (req.valid && req.ready) begin
                op_count++;
                predict_operation(req.op, req.object_key, req.object_size);
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the pinned LRU cache table: directed corner
// operations, then random operation mixes under several capacity settings.
// ----------------------------------------------------------------------------
module testbench;
    import plsc_pkg::*;

    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  KEY_POOL    = 20;

    logic clk;
    logic rst_n;
    int   fail_count, pending, op_count, result_count, evict_count;
    int   cycle_count = 0;
    int   stall_mode = 0;

    logic [31:0] key_pool[KEY_POOL];
    logic [CAP_BITS-1:0] capacity_now;

    plsc_req_if #(.KEY_BITS(32), .SIZE_BITS(40)) req_ch ();
    plsc_rsp_if rsp_ch ();
    plsc_cfg_if cfg_ch ();

    pinned_lru_size_cache_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    cache_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg          (cfg_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .op_count     (op_count),
        .result_count (result_count),
        .evict_count  (evict_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("pinned_lru_size_cache_table: mismatch");
            $finish;
        end
    end

    // Result side: the stall pattern switches now and again between always
    // ready, coin-flip ready and long stretches of back-pressure.
    always @(posedge clk)
    begin
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Present one operation and hold it until the transfer. Valid stays high
    // afterwards; the caller lowers it only when a gap follows.
    task automatic send_op(logic [3:0] op, logic [31:0] key, logic [CAP_BITS-1:0] size);
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.object_key  <= key;
        req_ch.object_size <= size;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic take_gap(int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Capacity changes only while nothing is in flight: drain, settle, write.
    task automatic set_capacity(logic [CAP_BITS-1:0] value);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        capacity_now = value;
    endtask

    // Mostly small objects so evictions stay cheap; now and then a size of
    // any width, which exercises every bit and the no-space path.
    function automatic logic [CAP_BITS-1:0] pick_size();
        if ($urandom_range(0, 11) == 0)
            return CAP_BITS'({$urandom, $urandom});
        if (capacity_now < 5000 && $urandom_range(0, 1))
            return CAP_BITS'($urandom_range(0, 400));
        return CAP_BITS'($urandom_range(0, 300));
    endfunction

    function automatic logic [3:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 34) return OP_INSERT;
        if (roll < 40) return OP_REMOVE;
        if (roll < 45) return OP_LOOKUP;
        if (roll < 50) return OP_DIRTY;
        if (roll < 54) return OP_CLEAN;
        if (roll < 66) return OP_ACQUIRE;
        if (roll < 78) return OP_RELEASE;
        if (roll < 84) return OP_PIN;
        if (roll < 93) return OP_UNPIN;
        if (roll < 97) return OP_CLEAR;
        return 4'($urandom_range(10, 15));  // undefined codes
    endfunction

    task automatic random_phase(int count);
        int burst;
        logic [31:0] key;
        burst = $urandom_range(1, 8);
        for (int n = 0; n < count; n++) begin
            key = ($urandom_range(0, 15) == 0) ? $urandom
                                               : key_pool[$urandom_range(0, KEY_POOL - 1)];
            send_op(pick_op(), key, pick_size());
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 8);
                // about one burst in three, at random, runs back to back with no gap
                take_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            end
        end
    endtask

    initial
    begin
        logic [31:0] kmax;
        capacity_now       = CAP_RESET;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_LOOKUP;
        req_ch.object_key  = '0;
        req_ch.object_size = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        kmax               = '1;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = kmax;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed corners at the reset capacity.
        send_op(OP_INSERT,  '0,   '0);
        send_op(OP_INSERT,  kmax, '1);          // evicts key 0, still no space
        send_op(OP_INSERT,  kmax, 40'd100);
        send_op(OP_LOOKUP,  kmax, '0);
        send_op(OP_DIRTY,   kmax, '0);
        send_op(OP_CLEAN,   kmax, '0);
        send_op(OP_ACQUIRE, kmax, '0);
        send_op(OP_REMOVE,  kmax, '0);          // refused: held
        send_op(OP_RELEASE, kmax, '0);
        send_op(OP_RELEASE, kmax, '0);          // count floors at zero
        send_op(OP_PIN,     kmax, '0);
        send_op(OP_REMOVE,  kmax, '0);          // refused: pinned
        send_op(OP_INSERT,  kmax, '1);          // present key, size ignored
        send_op(4'd10,      kmax, '0);
        send_op(4'd15,      32'h1234, '0);
        send_op(OP_UNPIN,   kmax, '0);
        send_op(OP_INSERT,  32'h5a5a5a5a, 40'd7);
        send_op(OP_CLEAR,   32'h5a5a5a5a, '0);  // both entries reported
        send_op(OP_REMOVE,  kmax, '0);          // not found
        send_op(OP_LOOKUP,  kmax, '0);
        send_op(OP_PIN,     32'h77, '0);
        send_op(OP_RELEASE, 32'h77, '0);
        send_op(OP_INSERT,  32'h77, '1);        // nothing evictable

        random_phase(45);
        set_capacity('1);
        random_phase(40);
        set_capacity('0);                       // below usage: forces evictions
        random_phase(36);
        set_capacity(40'd1500);
        random_phase(45);
        set_capacity(40'd400);
        random_phase(40);
        set_capacity(CAP_RESET);
        random_phase(41);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("ran %0d operations over six capacity settings, %0d results checked",
                 op_count, result_count);
        $display("%0d entries were evicted or cleared along the way", evict_count);
        if (fail_count == 0)
            $display("pinned_lru_size_cache_table: match");
        else
            $display("pinned_lru_size_cache_table: mismatch");
        $finish;
    end

endmodule
